// ===== rtl/lbc_pkg.sv =====
`timescale 1ns / 1ps

package lbc_pkg;

   // configuration register map
   typedef enum logic [2:0] {
      REG_WINDOW_LEFT   = 3'd0,
      REG_WINDOW_BOTTOM = 3'd1,
      REG_WINDOW_RIGHT  = 3'd2,
      REG_WINDOW_TOP    = 3'd3,
      REG_VIEW_LEFT     = 3'd4,
      REG_VIEW_BOTTOM   = 3'd5,
      REG_VIEW_RIGHT    = 3'd6,
      REG_VIEW_TOP      = 3'd7
   } reg_idx_type;

   localparam int NUM_REGS      = 8;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam int REG_RESET [NUM_REGS] = '{50, 50, 250, 250, 275, 275, 500, 500};

   // kind of one boundary test, travels with its ratio
   typedef struct packed {
      logic enter;
      logic leave;
      logic reject;
   } edge_flags_type;

endpackage

// ===== rtl/lbc_req_if.sv =====
`timescale 1ns / 1ps

interface lbc_req_if #(
   parameter int COORD_BITS = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== rtl/lbc_rsp_if.sv =====
`timescale 1ns / 1ps

interface lbc_rsp_if #(
   parameter int COORD_BITS = 16
) ();
   logic                         valid;
   logic                         ready;
   logic                         visible;
   logic signed [COORD_BITS-1:0] out_start_x;
   logic signed [COORD_BITS-1:0] out_start_y;
   logic signed [COORD_BITS-1:0] out_end_x;
   logic signed [COORD_BITS-1:0] out_end_y;

   modport source (output valid, visible, out_start_x, out_start_y, out_end_x, out_end_y,
                   input ready);
   modport sink   (input valid, visible, out_start_x, out_start_y, out_end_x, out_end_y,
                   output ready);
endinterface

// ===== rtl/line_clip_to_viewport.sv =====
// throughput: one item per cycle while the skid stage is empty; the boundary ratio divider
//   (FRAC_BITS + 1 steps) and the viewport divider (COORD_BITS + 2 steps) are both fully
//   pipelined, one bit per stage
// an output register and a one-entry skid stage; the input stalls once the skid stage is full
// reset: valid bits and the output stage clear, registers return to their reset values
`timescale 1ns / 1ps

module line_clip_to_viewport
   import lbc_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   lbc_req_if.sink                  req,
   lbc_rsp_if.source                rsp,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int CW      = COORD_BITS + 1;
   localparam int DW      = CW + FRAC_BITS + 1;
   localparam int TW      = FRAC_BITS + 2;
   localparam int RL      = FRAC_BITS + 3;
   localparam int ML      = COORD_BITS + 6;
   localparam int LAST    = RL + 3 + ML;
   localparam int ONE_VAL = 1 << FRAC_BITS;
   localparam logic signed [TW-1:0] T_ONE = TW'(ONE_VAL);

   logic [NUM_REGS-1:0][COORD_BITS-1:0] cfg_regs;
   logic signed [COORD_BITS-1:0] wl, wb, wr, wt, vl, vb, vr, vt;
   logic                         en;
   logic                         win_ok;

   // configuration registers
   lbc_csr #(.COORD_BITS(COORD_BITS)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .regs    (cfg_regs)
   );

   assign wl = $signed(cfg_regs[REG_WINDOW_LEFT]);
   assign wb = $signed(cfg_regs[REG_WINDOW_BOTTOM]);
   assign wr = $signed(cfg_regs[REG_WINDOW_RIGHT]);
   assign wt = $signed(cfg_regs[REG_WINDOW_TOP]);
   assign vl = $signed(cfg_regs[REG_VIEW_LEFT]);
   assign vb = $signed(cfg_regs[REG_VIEW_BOTTOM]);
   assign vr = $signed(cfg_regs[REG_VIEW_RIGHT]);
   assign vt = $signed(cfg_regs[REG_VIEW_TOP]);
   assign win_ok = (wr > wl) && (wt > wb);

   // input stage
   logic                         v_ff [0:LAST];
   logic signed [COORD_BITS-1:0] x0_ff, y0_ff, x1_ff, y1_ff;

   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '{default: 1'b0};
      end else if (en) begin
         v_ff[0] <= req.valid;
         for (int k = 1; k <= LAST; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= req.start_x;
         y0_ff <= req.start_y;
         x1_ff <= req.end_x;
         y1_ff <= req.end_y;
      end
   end

   // boundary terms
   logic signed [CW-1:0] dx, dy, bx, by;
   logic signed [CW-1:0] p_e [4];
   logic signed [CW-1:0] q_e [4];
   logic signed [TW-1:0] t_e [4];
   edge_flags_type       fl_e [4];

   assign dx = CW'(x1_ff) - CW'(x0_ff);
   assign dy = CW'(y1_ff) - CW'(y0_ff);
   assign bx = CW'(x0_ff) - CW'(wl);
   assign by = CW'(y0_ff) - CW'(wb);

   assign p_e[0] = -dx;
   assign q_e[0] = bx;
   assign p_e[1] = dx;
   assign q_e[1] = CW'(wr) - CW'(x0_ff);
   assign p_e[2] = -dy;
   assign q_e[2] = by;
   assign p_e[3] = dy;
   assign q_e[3] = CW'(wt) - CW'(y0_ff);

   for (genvar e = 0; e < 4; e++) begin : g_edge
      lbc_ratio #(.CW(CW), .FRAC_BITS(FRAC_BITS)) u_ratio (
         .clock (clock),
         .en    (en),
         .p     (p_e[e]),
         .q     (q_e[e]),
         .t     (t_e[e]),
         .flags (fl_e[e])
      );
   end

   // segment terms ride alongside the dividers
   logic [4*CW-1:0] sb_ff [1:RL];

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[1] <= {bx, by, dx, dy};
         for (int k = 2; k <= RL; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   // entry and exit parameters, accept test
   logic signed [TW-1:0] tl, tu;
   logic                 rej, clip_vis;
   logic [FRAC_BITS:0]   tl_ff, tu_ff;
   logic signed [CW-1:0] bx_c_ff, by_c_ff, dx_c_ff, dy_c_ff;
   logic                 vis_ff [RL+1:LAST];

   always_comb begin
      tl  = '0;
      tu  = T_ONE;
      rej = 1'b0;
      for (int e = 0; e < 4; e++) begin
         if (fl_e[e].enter && (t_e[e] > tl)) begin
            tl = t_e[e];
         end
         if (fl_e[e].leave && (t_e[e] < tu)) begin
            tu = t_e[e];
         end
         if (fl_e[e].reject) begin
            rej = 1'b1;
         end
      end
      clip_vis = win_ok && !rej && (tl <= tu);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tl_ff   <= tl[FRAC_BITS:0];
         tu_ff   <= tu[FRAC_BITS:0];
         bx_c_ff <= $signed(sb_ff[RL][4*CW-1:3*CW]);
         by_c_ff <= $signed(sb_ff[RL][3*CW-1:2*CW]);
         dx_c_ff <= $signed(sb_ff[RL][2*CW-1:CW]);
         dy_c_ff <= $signed(sb_ff[RL][CW-1:0]);
         vis_ff[RL+1] <= clip_vis;
         for (int k = RL + 2; k <= LAST; k++) begin
            vis_ff[k] <= vis_ff[k-1];
         end
      end
   end

   // clipped endpoints
   logic signed [DW-1:0] d_sx, d_sy, d_ex, d_ey;

   lbc_interp #(.CW(CW), .FRAC_BITS(FRAC_BITS)) u_interp_sx (
      .clock (clock), .en (en), .t (tl_ff), .delta (dx_c_ff), .base (bx_c_ff), .d (d_sx)
   );
   lbc_interp #(.CW(CW), .FRAC_BITS(FRAC_BITS)) u_interp_sy (
      .clock (clock), .en (en), .t (tl_ff), .delta (dy_c_ff), .base (by_c_ff), .d (d_sy)
   );
   lbc_interp #(.CW(CW), .FRAC_BITS(FRAC_BITS)) u_interp_ex (
      .clock (clock), .en (en), .t (tu_ff), .delta (dx_c_ff), .base (bx_c_ff), .d (d_ex)
   );
   lbc_interp #(.CW(CW), .FRAC_BITS(FRAC_BITS)) u_interp_ey (
      .clock (clock), .en (en), .t (tu_ff), .delta (dy_c_ff), .base (by_c_ff), .d (d_ey)
   );

   // window to viewport
   logic signed [COORD_BITS-1:0] m_sx, m_sy, m_ex, m_ey;

   lbc_map #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_map_sx (
      .clock (clock), .en (en), .d (d_sx), .wlo (wl), .whi (wr), .vlo (vl), .vhi (vr),
      .v (m_sx)
   );
   lbc_map #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_map_sy (
      .clock (clock), .en (en), .d (d_sy), .wlo (wb), .whi (wt), .vlo (vb), .vhi (vt),
      .v (m_sy)
   );
   lbc_map #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_map_ex (
      .clock (clock), .en (en), .d (d_ex), .wlo (wl), .whi (wr), .vlo (vl), .vhi (vr),
      .v (m_ex)
   );
   lbc_map #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_map_ey (
      .clock (clock), .en (en), .d (d_ey), .wlo (wb), .whi (wt), .vlo (vb), .vhi (vt),
      .v (m_ey)
   );

   // output register and skid stage
   logic                         new_vld;
   logic                         new_vis;
   logic signed [COORD_BITS-1:0] new_sx, new_sy, new_ex, new_ey;
   logic                         take;

   logic                         out_valid_ff, out_vis_ff;
   logic signed [COORD_BITS-1:0] out_sx_ff, out_sy_ff, out_ex_ff, out_ey_ff;
   logic                         sk_valid_ff, sk_vis_ff;
   logic signed [COORD_BITS-1:0] sk_sx_ff, sk_sy_ff, sk_ex_ff, sk_ey_ff;

   assign en      = !sk_valid_ff;
   assign take    = out_valid_ff && rsp.ready;
   assign new_vld = en && v_ff[LAST];
   assign new_vis = vis_ff[LAST];
   assign new_sx  = new_vis ? m_sx : '0;
   assign new_sy  = new_vis ? m_sy : '0;
   assign new_ex  = new_vis ? m_ex : '0;
   assign new_ey  = new_vis ? m_ey : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sk_valid_ff  <= 1'b0;
      end else begin
         priority if (sk_valid_ff) begin
            if (take) begin
               sk_valid_ff <= 1'b0;
            end
         end else if (new_vld) begin
            if (!out_valid_ff || take) begin
               out_valid_ff <= 1'b1;
            end else begin
               sk_valid_ff <= 1'b1;
            end
         end else if (take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (sk_valid_ff) begin
         if (take) begin
            out_vis_ff <= sk_vis_ff;
            out_sx_ff  <= sk_sx_ff;
            out_sy_ff  <= sk_sy_ff;
            out_ex_ff  <= sk_ex_ff;
            out_ey_ff  <= sk_ey_ff;
         end
      end else if (new_vld) begin
         if (!out_valid_ff || take) begin
            out_vis_ff <= new_vis;
            out_sx_ff  <= new_sx;
            out_sy_ff  <= new_sy;
            out_ex_ff  <= new_ex;
            out_ey_ff  <= new_ey;
         end else begin
            sk_vis_ff <= new_vis;
            sk_sx_ff  <= new_sx;
            sk_sy_ff  <= new_sy;
            sk_ex_ff  <= new_ex;
            sk_ey_ff  <= new_ey;
         end
      end else begin
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.visible     = out_vis_ff;
   assign rsp.out_start_x = out_sx_ff;
   assign rsp.out_start_y = out_sy_ff;
   assign rsp.out_end_x   = out_ex_ff;
   assign rsp.out_end_y   = out_ey_ff;

   // skid stage only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      sk_valid_ff |-> out_valid_ff)
      else $error("skid stage full while output register empty");

   // pipeline end holds while the skid stage is full
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_ff[LAST]))
      else $error("pipeline moved during stall");

   // rejected segments carry zero coordinates
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.visible) |->
         (rsp.out_start_x == '0 && rsp.out_start_y == '0 &&
          rsp.out_end_x == '0 && rsp.out_end_y == '0))
      else $error("rejected item with nonzero coordinates");

endmodule

// ===== rtl/lbc_csr.sv =====
`timescale 1ns / 1ps

module lbc_csr
   import lbc_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [CSR_ADDR_BITS-1:0]             paddr,
   input  logic [CSR_DATA_BITS-1:0]             pwdata,
   output logic [CSR_DATA_BITS-1:0]             prdata,
   output logic                                 pready,
   output logic [NUM_REGS-1:0][COORD_BITS-1:0] regs
);

   logic [NUM_REGS-1:0][COORD_BITS-1:0] regs_ff;
   reg_idx_type                         idx;
   logic                                wr_en;

   assign idx    = reg_idx_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = CSR_DATA_BITS'(regs_ff[idx]);
   assign regs   = regs_ff;

   // register file, written in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= COORD_BITS'(REG_RESET[i]);
         end
      end else if (wr_en) begin
         regs_ff[idx] <= pwdata[COORD_BITS-1:0];
      end
   end

endmodule

// ===== rtl/lbc_ratio.sv =====
`timescale 1ns / 1ps

module lbc_ratio
   import lbc_pkg::*;
#(
   parameter int CW        = 17,
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [CW-1:0]         p,
   input  logic signed [CW-1:0]         q,
   output logic signed [FRAC_BITS+1:0]  t,
   output edge_flags_type               flags
);

   localparam int NB      = FRAC_BITS + 1;
   localparam int RW      = CW + 1;
   localparam int TW      = FRAC_BITS + 2;
   localparam int CAP_VAL = (1 << FRAC_BITS) + 1;
   localparam logic [NB-1:0] T_CAP = NB'(CAP_VAL);

   logic [CW-1:0]  aq_in;
   logic [CW-1:0]  ap_in;
   logic           big_in;
   logic           nneg_in;
   edge_flags_type flags_in;

   logic [RW-1:0]  r_ff    [0:NB-1];
   logic [CW-1:0]  ap_ff   [0:NB-1];
   logic [NB-1:0]  quo_ff  [0:NB];
   logic           big_ff  [0:NB];
   logic           nneg_ff [0:NB];
   edge_flags_type fl_ff   [0:NB];

   logic signed [TW-1:0] t_ff;
   logic signed [TW-1:0] t_in;
   edge_flags_type       flags_ff;

   // magnitudes and edge kind
   always_comb begin
      aq_in           = q[CW-1] ? CW'(-q) : CW'(q);
      ap_in           = p[CW-1] ? CW'(-p) : CW'(p);
      big_in          = {1'b0, aq_in} >= {ap_in, 1'b0};
      nneg_in         = (q != '0) && (q[CW-1] != p[CW-1]);
      flags_in.enter  = p[CW-1];
      flags_in.leave  = !p[CW-1] && (p != '0);
      flags_in.reject = (p == '0) && q[CW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= RW'(aq_in);
         ap_ff[0]   <= ap_in;
         quo_ff[0]  <= '0;
         big_ff[0]  <= big_in;
         nneg_ff[0] <= nneg_in;
         fl_ff[0]   <= flags_in;
      end
   end

   // restoring division, one quotient bit per stage, integer bit first
   for (genvar k = 1; k <= NB; k++) begin : g_step
      logic [RW-1:0] cand;
      logic          ge;

      if (k == 1) begin : g_first
         assign cand = r_ff[0];
      end else begin : g_next
         assign cand = r_ff[k-1] << 1;
      end
      assign ge = cand >= RW'(ap_ff[k-1]);

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[k]  <= {quo_ff[k-1][NB-2:0], ge};
            big_ff[k]  <= big_ff[k-1];
            nneg_ff[k] <= nneg_ff[k-1];
            fl_ff[k]   <= fl_ff[k-1];
         end
      end

      if (k < NB) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[k]  <= ge ? cand - RW'(ap_ff[k-1]) : cand;
               ap_ff[k] <= ap_ff[k-1];
            end
         end
      end
   end

   // clamp to -1 .. one plus one lsb
   always_comb begin
      if (nneg_ff[NB]) begin
         t_in = '1;
      end else if (big_ff[NB] || (quo_ff[NB] > T_CAP)) begin
         t_in = {1'b0, T_CAP};
      end else begin
         t_in = {1'b0, quo_ff[NB]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff     <= t_in;
         flags_ff <= fl_ff[NB];
      end
   end

   assign t     = t_ff;
   assign flags = flags_ff;

endmodule

// ===== rtl/lbc_interp.sv =====
`timescale 1ns / 1ps

module lbc_interp #(
   parameter int CW        = 17,
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic [FRAC_BITS:0]              t,
   input  logic signed [CW-1:0]            delta,
   input  logic signed [CW-1:0]            base,
   output logic signed [CW+FRAC_BITS:0]    d
);

   localparam int DW  = CW + FRAC_BITS + 1;
   localparam int PRW = FRAC_BITS + 2 + CW;

   logic signed [PRW-1:0] prod_ff;
   logic signed [PRW-1:0] prod_in;
   logic signed [CW-1:0]  base_ff;
   logic signed [DW-1:0]  d_ff;
   logic signed [DW-1:0]  d_in;

   // t times delta
   assign prod_in = PRW'($signed({1'b0, t})) * PRW'(delta);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         base_ff <= base;
      end
   end

   // offset from the window edge, fixed point
   assign d_in = (DW'(base_ff) <<< FRAC_BITS) + DW'(prod_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
      end
   end

   assign d = d_ff;

endmodule

// ===== rtl/lbc_map.sv =====
`timescale 1ns / 1ps

module lbc_map #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [COORD_BITS+FRAC_BITS+1:0] d,
   input  logic signed [COORD_BITS-1:0]       wlo,
   input  logic signed [COORD_BITS-1:0]       whi,
   input  logic signed [COORD_BITS-1:0]       vlo,
   input  logic signed [COORD_BITS-1:0]       vhi,
   output logic signed [COORD_BITS-1:0]       v
);

   localparam int CW = COORD_BITS + 1;
   localparam int DW = CW + FRAC_BITS + 1;
   localparam int PW = DW + CW;
   localparam int AW = PW + 1 - FRAC_BITS;
   localparam int QB = COORD_BITS + 2;
   localparam int SW = QB + 2;
   localparam logic signed [SW-1:0] LIM_HI = SW'((longint'(1) <<< (COORD_BITS - 1)) - 1);
   localparam logic signed [SW-1:0] LIM_LO = -LIM_HI - SW'(1);

   logic signed [CW-1:0] s;
   logic [CW-1:0]        w;

   logic [DW-1:0] ad_ff;
   logic [CW-1:0] as_ff;
   logic          neg0_ff;
   logic [PW-1:0] prod_ff;
   logic          neg1_ff;

   logic [PW:0]   sum_w;
   logic [AW-1:0] a_val;
   logic          ovf_in;

   logic [CW-1:0] r_ff    [0:QB-1];
   logic [QB-1:0] alow_ff [0:QB-1];
   logic [QB-1:0] quo_ff  [0:QB];
   logic          ovf_ff  [0:QB];
   logic          neg_ff  [0:QB];

   logic signed [SW-1:0]         vlo_x;
   logic signed [SW-1:0]         mag_s;
   logic signed [SW-1:0]         sum;
   logic signed [COORD_BITS-1:0] v_in;
   logic signed [COORD_BITS-1:0] v_ff;

   assign s = CW'(vhi) - CW'(vlo);
   assign w = CW'(whi) - CW'(wlo);

   // magnitudes and result sign
   always_ff @(posedge clock) begin
      if (en) begin
         ad_ff   <= d[DW-1] ? DW'(-d) : DW'(d);
         as_ff   <= s[CW-1] ? CW'(-s) : CW'(s);
         neg0_ff <= d[DW-1] != s[CW-1];
      end
   end

   // scale product
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PW'(ad_ff) * PW'(as_ff);
         neg1_ff <= neg0_ff;
      end
   end

   // add half the divisor, drop the fraction scale, flag a quotient out of range
   assign sum_w  = {1'b0, prod_ff} + ((PW + 1)'(w) << (FRAC_BITS - 1));
   assign a_val  = sum_w[PW:FRAC_BITS];
   assign ovf_in = a_val >= (AW'(w) << QB);

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= CW'(a_val >> QB);
         alow_ff[0] <= a_val[QB-1:0];
         quo_ff[0]  <= '0;
         ovf_ff[0]  <= ovf_in;
         neg_ff[0]  <= neg1_ff;
      end
   end

   // long division by the window width, one bit per stage
   for (genvar j = 1; j <= QB; j++) begin : g_step
      logic [CW:0] cand;
      logic        ge;

      assign cand = {r_ff[j-1], alow_ff[j-1][QB-j]};
      assign ge   = cand >= {1'b0, w};

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[j] <= {quo_ff[j-1][QB-2:0], ge};
            ovf_ff[j] <= ovf_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end

      if (j < QB) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[j]    <= ge ? CW'(cand - {1'b0, w}) : CW'(cand);
               alow_ff[j] <= alow_ff[j-1];
            end
         end
      end
   end

   // offset into the viewport and saturate
   always_comb begin
      vlo_x = SW'(vlo);
      mag_s = $signed(SW'(quo_ff[QB]));
      sum   = neg_ff[QB] ? vlo_x - mag_s : vlo_x + mag_s;
      if (ovf_ff[QB]) begin
         v_in = neg_ff[QB] ? LIM_LO[COORD_BITS-1:0] : LIM_HI[COORD_BITS-1:0];
      end else if (sum > LIM_HI) begin
         v_in = LIM_HI[COORD_BITS-1:0];
      end else if (sum < LIM_LO) begin
         v_in = LIM_LO[COORD_BITS-1:0];
      end else begin
         v_in = sum[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in;
      end
   end

   assign v = v_ff;

endmodule

// ===== dv/tb_line_clip_to_viewport.sv =====
`timescale 1ns / 1ps

module tb_line_clip_to_viewport
   import lbc_pkg::*;
;

   localparam longint ONE       = 64'sd1 <<< 16;
   localparam int     DRAIN_CYC = 80;

   typedef struct packed {
      logic               visible;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] ex;
      logic signed [15:0] ey;
   } clip_result_type;

   typedef struct {
      logic signed [15:0] x0, y0, x1, y1;
      bit                 typed;
      clip_result_type    want;
   } seg_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   lbc_req_if #(.COORD_BITS(16)) req_if ();
   lbc_rsp_if #(.COORD_BITS(16)) rsp_if ();

   line_clip_to_viewport dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow copy of the window and viewport registers
   logic signed [15:0] cfg [NUM_REGS];
   clip_result_type    pending_clips [$];
   int                 errors     = 0;
   int                 stall_pct  = 0;
   int                 idle_pct   = 0;
   int                 hold_asked = 0;
   int                 hold_done  = 0;
   int                 hold_left  = 0;
   int                 run_left   = 0;

   always #6 clock = ~clock;

   initial begin
      #5_000_000;
      $display("** line_clip_to_viewport: FAILED **");
      $finish;
   end

   // one boundary test, narrows the entry/exit interval
   function automatic bit edge_ok(longint p, longint q, inout longint tl, inout longint tu);
      longint n, d, t;
      if (p == 0) return q >= 0;
      n = q * ONE;
      d = p;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      if (n >= 0) t = n / d;
      else t = -((-n + d - 1) / d);
      if (t < -1) t = -1;
      if (t > ONE + 1) t = ONE + 1;
      if (p < 0) begin
         if (t > tl) tl = t;
         if (t > tu) return 1'b0;
      end else begin
         if (t < tu) tu = t;
         if (t < tl) return 1'b0;
      end
      return 1'b1;
   endfunction

   // window to viewport, rounded half away from zero, saturated
   function automatic logic signed [15:0] map_axis(longint pt, longint wlo, longint whi,
                                                   longint vlo, longint vhi);
      longint     d, s, q, v;
      logic [127:0] num, den, quo;
      d   = pt - wlo * ONE;
      s   = vhi - vlo;
      den = 128'((whi - wlo) * ONE);
      num = 128'(d < 0 ? -d : d) * 128'(s < 0 ? -s : s) + (den >> 1);
      quo = num / den;
      if (quo > (128'd1 << 62)) quo = 128'd1 << 62;
      q = longint'(quo[63:0]);
      if ((d < 0) != (s < 0)) q = -q;
      v = vlo + q;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic clip_result_type clip_segment(
         logic signed [15:0] x0, logic signed [15:0] y0,
         logic signed [15:0] x1, logic signed [15:0] y1);
      longint          ax0, ay0, dx, dy, tl, tu, wl, wb, wr, wt;
      bit              ok;
      clip_result_type r;
      ax0 = x0;
      ay0 = y0;
      dx  = longint'(x1) - ax0;
      dy  = longint'(y1) - ay0;
      wl  = cfg[REG_WINDOW_LEFT];
      wb  = cfg[REG_WINDOW_BOTTOM];
      wr  = cfg[REG_WINDOW_RIGHT];
      wt  = cfg[REG_WINDOW_TOP];
      tl  = 0;
      tu  = ONE;
      r   = '0;
      ok  = (wr > wl) && (wt > wb);
      ok  = ok && edge_ok(-dx, ax0 - wl, tl, tu);
      ok  = ok && edge_ok(dx, wr - ax0, tl, tu);
      ok  = ok && edge_ok(-dy, ay0 - wb, tl, tu);
      ok  = ok && edge_ok(dy, wt - ay0, tl, tu);
      if (!ok) return r;
      r.visible = 1'b1;
      r.sx = map_axis(ax0 * ONE + tl * dx, wl, wr, cfg[REG_VIEW_LEFT], cfg[REG_VIEW_RIGHT]);
      r.sy = map_axis(ay0 * ONE + tl * dy, wb, wt, cfg[REG_VIEW_BOTTOM], cfg[REG_VIEW_TOP]);
      r.ex = map_axis(ax0 * ONE + tu * dx, wl, wr, cfg[REG_VIEW_LEFT], cfg[REG_VIEW_RIGHT]);
      r.ey = map_axis(ay0 * ONE + tu * dy, wb, wt, cfg[REG_VIEW_BOTTOM], cfg[REG_VIEW_TOP]);
      return r;
   endfunction

   // setup then access cycle, upper data bits are junk
   task automatic csr_write(reg_idx_type idx, logic signed [15:0] val);
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {idx, 2'b00};
      csr_pwdata <= {16'($urandom), val};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg[idx] = val;
   endtask

   task automatic set_view(logic signed [15:0] wl, logic signed [15:0] wb,
                           logic signed [15:0] wr, logic signed [15:0] wt,
                           logic signed [15:0] vl, logic signed [15:0] vb,
                           logic signed [15:0] vr, logic signed [15:0] vt);
      csr_write(REG_WINDOW_LEFT, wl);
      csr_write(REG_WINDOW_BOTTOM, wb);
      csr_write(REG_WINDOW_RIGHT, wr);
      csr_write(REG_WINDOW_TOP, wt);
      csr_write(REG_VIEW_LEFT, vl);
      csr_write(REG_VIEW_BOTTOM, vb);
      csr_write(REG_VIEW_RIGHT, vr);
      csr_write(REG_VIEW_TOP, vt);
   endtask

   // called at a falling edge, returns at the falling edge after the accept
   task automatic send_segment(logic signed [15:0] x0, logic signed [15:0] y0,
                               logic signed [15:0] x1, logic signed [15:0] y1,
                               bit typed, clip_result_type want);
      req_if.valid   <= 1'b1;
      req_if.start_x <= x0;
      req_if.start_y <= y0;
      req_if.end_x   <= x1;
      req_if.end_y   <= y1;
      do @(posedge clock); while (!req_if.ready);
      pending_clips.push_back(typed ? want : clip_segment(x0, y0, x1, y1));
      @(negedge clock);
   endtask

   task automatic idle_gap();
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   task automatic wait_drain();
      while (pending_clips.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   function automatic logic signed [15:0] near_coord(longint lo, longint hi);
      longint a, b, m, v;
      a = lo < hi ? lo : hi;
      b = lo < hi ? hi : lo;
      m = (b - a) / 4 + 4;
      v = a - m + longint'($urandom_range(0, 32'(b - a + 2 * m)));
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // random segments, mostly around the window with some axis-aligned, some with extreme coordinates and some raw ones
   task automatic random_segments(int count);
      logic signed [15:0] x0, y0, x1, y1;
      int                 kind, burst;
      burst = 0;
      @(negedge clock);
      repeat (count) begin
         kind = $urandom_range(0, 9);
         x0 = near_coord(cfg[REG_WINDOW_LEFT], cfg[REG_WINDOW_RIGHT]);
         x1 = near_coord(cfg[REG_WINDOW_LEFT], cfg[REG_WINDOW_RIGHT]);
         y0 = near_coord(cfg[REG_WINDOW_BOTTOM], cfg[REG_WINDOW_TOP]);
         y1 = near_coord(cfg[REG_WINDOW_BOTTOM], cfg[REG_WINDOW_TOP]);
         if (kind < 2) begin
            x0 = 16'($urandom);
            y0 = 16'($urandom);
            x1 = 16'($urandom);
            y1 = 16'($urandom);
         end else if (kind == 2) begin
            x1 = x0;
         end else if (kind == 3) begin
            y1 = y0;
         end else if (kind == 4) begin
            x0 = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            y1 = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         end
         if (burst == 0) begin
            burst = $urandom_range(1, 20);
            if ($urandom_range(0, 99) < idle_pct) idle_gap();
         end
         burst--;
         send_segment(x0, y0, x1, y1, 1'b0, '0);
      end
      req_if.valid <= 1'b0;
   endtask

   // receiver stalls in runs, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_done != hold_asked) begin
         hold_done    <= hold_asked;
         hold_left    <= 300;
         rsp_if.ready <= 1'b0;
      end else if (run_left == 0) begin
         run_left     <= $urandom_range(1, 12);
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end else begin
         run_left <= run_left - 1;
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      clip_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_clips.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
         end else begin
            want = pending_clips.pop_front();
            if (rsp_if.visible !== want.visible) begin
               $error("visible: expected %0d, got %0d", want.visible, rsp_if.visible);
               errors++;
            end
            if (rsp_if.out_start_x !== want.sx) begin
               $error("out_start_x: expected %0d, got %0d", want.sx, rsp_if.out_start_x);
               errors++;
            end
            if (rsp_if.out_start_y !== want.sy) begin
               $error("out_start_y: expected %0d, got %0d", want.sy, rsp_if.out_start_y);
               errors++;
            end
            if (rsp_if.out_end_x !== want.ex) begin
               $error("out_end_x: expected %0d, got %0d", want.ex, rsp_if.out_end_x);
               errors++;
            end
            if (rsp_if.out_end_y !== want.ey) begin
               $error("out_end_y: expected %0d, got %0d", want.ey, rsp_if.out_end_y);
               errors++;
            end
         end
      end
   end

   initial begin
      seg_row_type     rows [22];
      clip_result_type none;
      none = '0;
      req_if.valid   = 1'b0;
      req_if.start_x = '0;
      req_if.start_y = '0;
      req_if.end_x   = '0;
      req_if.end_y   = '0;
      rsp_if.ready   = 1'b0;
      for (int i = 0; i < NUM_REGS; i++) cfg[i] = 16'(REG_RESET[i]);

      // directed rows, reset window 50..250 onto viewport 275..500
      rows[0]  = '{100, 100, 200, 200, 1'b0, none};
      rows[1]  = '{50, 50, 250, 250, 1'b1, '{1'b1, 16'sd275, 16'sd275, 16'sd500, 16'sd500}};
      rows[2]  = '{250, 250, 50, 50, 1'b1, '{1'b1, 16'sd500, 16'sd500, 16'sd275, 16'sd275}};
      rows[3]  = '{0, 0, 0, 300, 1'b1, none};
      rows[4]  = '{0, 0, 0, 0, 1'b1, none};
      rows[5]  = '{-1, -1, -1, -1, 1'b1, none};
      rows[6]  = '{-32768, -32768, 32767, 32767, 1'b0, none};
      rows[7]  = '{32767, -32768, -32768, 32767, 1'b0, none};
      rows[8]  = '{32767, 32767, 32767, 32767, 1'b1, none};
      rows[9]  = '{-32768, -32768, -32768, -32768, 1'b1, none};
      rows[10] = '{150, 150, 150, 150, 1'b0, none};
      rows[11] = '{0, 150, 300, 150, 1'b0, none};
      rows[12] = '{150, 0, 150, 300, 1'b0, none};
      rows[13] = '{0, 240, 40, 300, 1'b0, none};
      rows[14] = '{0, 200, 100, 300, 1'b0, none};
      rows[15] = '{300, 300, 400, 400, 1'b1, none};
      rows[16] = '{260, 150, 300, 150, 1'b1, none};
      rows[17] = '{-32768, 150, 32767, 151, 1'b0, none};
      rows[18] = '{150, 32767, 151, -32768, 1'b0, none};
      rows[19] = '{51, 249, 249, 51, 1'b0, none};
      rows[20] = '{-21846, 21845, 21845, -21846, 1'b0, none};
      rows[21] = '{49, 49, 251, 251, 1'b0, none};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      @(negedge clock);
      foreach (rows[i]) send_segment(rows[i].x0, rows[i].y0, rows[i].x1, rows[i].y1,
                                     rows[i].typed, rows[i].want);
      req_if.valid <= 1'b0;
      wait_drain();

      // zero-size window rejects all
      set_view(100, -50, 100, 400, 0, 0, 640, 480);
      @(negedge clock);
      send_segment(100, 0, 100, 300, 1'b1, none);
      send_segment(-32768, -32768, 32767, 32767, 1'b1, none);
      req_if.valid <= 1'b0;
      idle_pct = 30;
      random_segments(40);
      wait_drain();

      // inverted viewport
      stall_pct = 30;
      set_view(-100, -100, 100, 100, 500, 400, -500, -400);
      random_segments(95);
      wait_drain();

      // full-range window and viewport
      stall_pct = 0;
      idle_pct  = 0;
      set_view(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
      random_segments(95);
      wait_drain();

      // tiny window onto a huge viewport, saturates
      stall_pct = 50;
      idle_pct  = 60;
      set_view(0, 0, 1, 1, -32768, 32767, 32767, -32768);
      random_segments(95);
      wait_drain();

      // long receiver hold-off while items keep coming
      stall_pct = 10;
      idle_pct  = 0;
      set_view(-300, -200, 300, 200, 0, 0, 1919, 1079);
      hold_asked++;
      random_segments(150);
      wait_drain();

      // random settings
      repeat (5) begin
         stall_pct = $urandom_range(0, 70);
         idle_pct  = $urandom_range(0, 80);
         set_view(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         if (cfg[REG_WINDOW_RIGHT] <= cfg[REG_WINDOW_LEFT] && $urandom_range(0, 3) != 0) begin
            csr_write(REG_WINDOW_LEFT, cfg[REG_WINDOW_RIGHT]);
            csr_write(REG_WINDOW_RIGHT, 16'($urandom_range(0, 1) ? 32767 : 1000));
         end
         if (cfg[REG_WINDOW_TOP] <= cfg[REG_WINDOW_BOTTOM] && $urandom_range(0, 3) != 0) begin
            csr_write(REG_WINDOW_BOTTOM, cfg[REG_WINDOW_TOP]);
            csr_write(REG_WINDOW_TOP, 16'($urandom_range(0, 1) ? 32767 : 1000));
         end
         random_segments(95);
         wait_drain();
      end

      if (errors == 0) begin
         $display("** line_clip_to_viewport: PASSED **");
      end else begin
         $display("** line_clip_to_viewport: FAILED **");
      end
      $finish;
   end

endmodule
